// ===== rtl/core/bcc_pkg.sv =====
// bcc_pkg: shared constants and controller/datapath types for the binomial/catalan block
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned VAL_W   = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned DIGIT_W = 8;
    localparam int unsigned STEPS   = VAL_W / DIGIT_W;
    localparam int unsigned STEP_W  = $clog2(STEPS);

    localparam logic [IDX_W-1:0] MAX_CATALAN_INDEX = 7'd62;

    localparam logic OP_BINOMIAL = 1'b0;
    localparam logic OP_CATALAN  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_K_GT_N  = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic load;        // capture a new request
        logic mul;         // value <= value * (top - i), top being n or 2n for catalan
        logic div_init;    // clear remainder and digit counter, pick divisor
        logic div_final;   // divisor is n + 1 instead of i + 1
        logic div_step;    // one radix-256 digit of the long division
        logic inc_i;       // next round of the multiplicative loop
        logic load_out;    // move finished value into the output register
    } bcc_cmd_t;

    typedef struct packed {
        logic err;         // request carries a nonzero status
        logic catalan;     // catalan request
        logic loop_done;   // all rounds finished
        logic div_last;    // last digit of the division
    } bcc_sts_t;

endpackage

// ===== rtl/core/bcc_ifs.sv =====
// bcc_ifs: request and response channel interfaces
`timescale 1ns / 1ps

interface bcc_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] n;
    logic [6:0] k;

    modport source (output valid, output operation, output n, output k, input ready);
    modport sink   (input valid, input operation, input n, input k, output ready);
endinterface

interface bcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [1:0]  status;

    modport source (output valid, output result_low, output result_high, output status,
                    input ready);
    modport sink   (input valid, input result_low, input result_high, input status,
                    output ready);
endinterface

// ===== rtl/core/binomial_catalan_calculator.sv =====
// binomial_catalan_calculator: top level joining the controller and the datapath
//
//  channel  role  transaction contents
//  req      sink  operation (0 binomial, 1 catalan), n, k
//  rsp      src   result_low, result_high, status
//
//  an item runs r = min(k, n-k) or n rounds, then catalan divides by n + 1
//  each round is a 128x7 multiply and a radix-256 long division
//  at most 63 rounds (binomial with n up to 127); error requests skip the rounds
//  rst_n clears the state machine and the response valid flag
//  a finished result sits in the output register while the next request is taken
`timescale 1ns / 1ps

module binomial_catalan_calculator (
    input logic         clk,
    input logic         rst_n,
    bcc_req_if.sink     req,
    bcc_rsp_if.source   rsp
);
    import bcc_pkg::*;

    bcc_cmd_t cmd;
    bcc_sts_t sts;

    bcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bcc_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (req.operation),
        .n           (req.n),
        .k           (req.k),
        .result_low  (rsp.result_low),
        .result_high (rsp.result_high),
        .status      (rsp.status)
    );

endmodule

// ===== rtl/core/bcc_ctrl.sv =====
// bcc_ctrl: sequencing state machine for the multiply/divide rounds
`timescale 1ns / 1ps

module bcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bcc_pkg::bcc_cmd_t cmd,
    input  bcc_pkg::bcc_sts_t sts
);
    import bcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOP = 5'b00010,
        S_DIV  = 5'b00100,
        S_FDIV = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (sts.err || sts.loop_done)
                begin
                    if (sts.catalan && !sts.err)
                    begin
                        cmd.div_init  = 1'b1;
                        cmd.div_final = 1'b1;
                        state_next    = S_FDIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.mul      = 1'b1;
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/bcc_datapath.sv =====
// bcc_datapath: 128-bit value register, small multiplier, radix-256 divider, output register
`timescale 1ns / 1ps

module bcc_datapath (
    input  logic                     clk,
    input  bcc_pkg::bcc_cmd_t        cmd,
    output bcc_pkg::bcc_sts_t        sts,
    input  logic                     operation,
    input  logic [6:0]               n,
    input  logic [6:0]               k,
    output logic [63:0]              result_low,
    output logic [63:0]              result_high,
    output logic [1:0]               status
);
    import bcc_pkg::*;

    logic [VAL_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]   top_reg;       // n, or 2n for catalan
    logic [IDX_W-1:0]   n_reg;
    logic [CNT_W-1:0]   kk_reg;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic               cat_reg;
    logic [1:0]         status_reg;
    logic [IDX_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]   div_reg;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [HALF_W-1:0]  res_lo_reg;
    logic [HALF_W-1:0]  res_hi_reg;
    logic [1:0]         res_st_reg;

    // request decode
    logic               k_gt_n;
    logic               n_range;
    logic [IDX_W-1:0]   n_minus_k;
    logic [IDX_W-1:0]   kk_bin;
    logic [1:0]         st_in;

    // arithmetic
    logic [IDX_W-1:0]   mult;
    logic [VAL_W-1:0]   prod;
    logic [DIGIT_W-1:0] q_digit;
    logic [IDX_W-1:0]   r_step;
    logic [IDX_W:0]     trial;

    always_comb
    begin
        k_gt_n    = (k > n);
        n_range   = (n > MAX_CATALAN_INDEX);
        n_minus_k = n - k;
        kk_bin    = (k > n_minus_k) ? n_minus_k : k;
        if (operation == OP_BINOMIAL)
        begin
            st_in = k_gt_n ? ST_K_GT_N : ST_OK;
        end
        else
        begin
            st_in = n_range ? ST_RANGE : ST_OK;
        end
    end

    assign mult = top_reg - IDX_W'(i_reg);
    assign prod = val_reg * VAL_W'(mult);

    // eight restoring steps on the top byte; remainder stays below the divisor
    always_comb
    begin
        r_step  = rem_reg;
        q_digit = '0;
        trial   = '0;
        for (int j = 0; j < DIGIT_W; j++)
        begin
            trial = {r_step, val_reg[VAL_W-1-j]};
            if (trial >= {1'b0, div_reg})
            begin
                trial              = trial - {1'b0, div_reg};
                q_digit[DIGIT_W-1-j] = 1'b1;
            end
            r_step = trial[IDX_W-1:0];
        end
    end

    always_comb
    begin
        val_next = val_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        i_next   = i_reg;
        if (cmd.load)
        begin
            val_next = (st_in == ST_OK) ? VAL_W'(1) : '0;
            i_next   = '0;
        end
        if (cmd.mul)
        begin
            val_next = prod;
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            val_next = {val_reg[VAL_W-DIGIT_W-1:0], q_digit};
            rem_next = r_step;
            cnt_next = cnt_reg + STEP_W'(1);
        end
        if (cmd.inc_i)
        begin
            i_next = i_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        i_reg   <= i_next;
        if (cmd.load)
        begin
            n_reg      <= n;
            cat_reg    <= operation;
            status_reg <= st_in;
            if (operation == OP_CATALAN)
            begin
                top_reg <= {n[IDX_W-2:0], 1'b0};
                kk_reg  <= n[CNT_W-1:0];
            end
            else
            begin
                top_reg <= n;
                kk_reg  <= kk_bin[CNT_W-1:0];
            end
        end
        if (cmd.div_init)
        begin
            div_reg <= cmd.div_final ? (n_reg + IDX_W'(1)) : (IDX_W'(i_reg) + IDX_W'(1));
        end
        if (cmd.load_out)
        begin
            res_lo_reg <= val_reg[HALF_W-1:0];
            res_hi_reg <= val_reg[VAL_W-1:HALF_W];
            res_st_reg <= status_reg;
        end
    end

    always_comb
    begin
        sts.err       = (status_reg != ST_OK);
        sts.catalan   = (cat_reg == OP_CATALAN);
        sts.loop_done = (i_reg == kk_reg);
        sts.div_last  = (cnt_reg == STEP_W'(STEPS - 1));
    end

    assign result_low  = res_lo_reg;
    assign result_high = res_hi_reg;
    assign status      = res_st_reg;

endmodule
